### src/lzwz_pkg.sv
// ----------------------------------------------------------------------------
// lzwz_pkg
// shared types and constants of the .Z lzw decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lzwz_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_DEC,
        S_WALK,
        S_READ
    } t_state;

    localparam logic [2:0] ST_BYTE     = 3'd0;
    localparam logic [2:0] ST_NEED     = 3'd1;
    localparam logic [2:0] ST_ACCEPTED = 3'd2;
    localparam logic [2:0] ST_REFUSED  = 3'd3;
    localparam logic [2:0] ST_FINISHED = 3'd4;
    localparam logic [2:0] ST_ERROR    = 3'd5;

    localparam logic       OP_FEED     = 1'b0;

    localparam logic [7:0] HDR_RESET   = 8'd144;
    localparam logic [4:0] MIN_BITS    = 5'd9;
    localparam int         CLEAR_CODE  = 256;
    localparam int         FIRST_FREE  = 257;
    localparam int         GROUP_BITS  = 128;

endpackage
`default_nettype wire

### src/lzwz_code_unpack.sv
// ----------------------------------------------------------------------------
// lzwz_code_unpack
// shift unit that pulls the next lsb-first code out of the byte group
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lzwz_code_unpack #(
    parameter int MAX_CODE_BITS = 16
) (
    input  wire logic [lzwz_pkg::GROUP_BITS-1:0] i_group,
    input  wire logic [7:0]                      i_bit_pos,
    input  wire logic [4:0]                      i_code_width,
    input  wire logic [4:0]                      i_group_count,
    output logic      [MAX_CODE_BITS-1:0]        o_code,
    output logic                                 o_ready
);
    localparam int M = MAX_CODE_BITS;

    logic [lzwz_pkg::GROUP_BITS+15:0] w_shift;
    logic [M:0]                       w_mask;

    always_comb begin
        w_shift = {16'h0, i_group} >> i_bit_pos;
        w_mask  = ((M+1)'(1) << i_code_width) - (M+1)'(1);
        o_code  = w_shift[M-1:0] & w_mask[M-1:0];
        o_ready = ({1'b0, i_bit_pos} + {4'h0, i_code_width}) <= {1'b0, i_group_count, 3'b000};
    end
endmodule
`default_nettype wire

### src/lzw_compress_z_decoder_top.sv
// ----------------------------------------------------------------------------
// lzw_compress_z_decoder_top
// unix compress (.Z) lzw decoder with feed and fetch transfers
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request per transfer: tuser is the opcode (0 feed,
//   1 fetch), tdata the compressed byte, tlast marks the final fed byte.
//   m_axis returns exactly one result per request: tdata the decoded byte,
//   tuser the status code.
//   i_cfg_we writes the header byte and restarts the stream state.
// request flow:
//   feed and error-state answers: result registered in the next cycle.
//   fetch from a filled stack: via the POP state (stack memory read).
//   fetch that decodes a code: DEC, then WALK/READ in turn along the chain;
//   DEC repeats per clear code skipped; one dictionary read per walk step.
//   one request is in flight at a time; s_axis_tready is low meanwhile.
// reset:
//   synchronous active low; header returns to 0x90, dictionary memories keep
//   their contents, no clearing pass.
// stall:
//   a result waits in the output register while m_axis_tready is low; a new
//   request is taken in the cycle that result leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lzw_compress_z_decoder_top #(
    parameter int MAX_CODE_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // in_byte
    input  wire logic       s_axis_tuser,   // opcode
    input  wire logic       s_axis_tlast,   // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // out_byte
    output logic [2:0]      m_axis_tuser    // status
);
    localparam int M     = MAX_CODE_BITS;
    localparam int DEPTH = 1 << M;

    lzwz_pkg::t_state r_state, n_state;
    logic [7:0]   r_hdr, n_hdr;
    logic [lzwz_pkg::GROUP_BITS-1:0] r_grp, n_grp;
    logic [4:0]   r_gc, n_gc, r_disc, n_disc, r_cw, n_cw;
    logic [7:0]   r_bp, n_bp;
    logic [M:0]   r_nfc, n_nfc;
    logic         r_prev, n_prev, r_end, n_end, r_err, n_err;
    logic [M-1:0] r_depth, n_depth, r_sym, n_sym, r_cur, n_cur, r_steps, n_steps;
    logic         r_ov, n_ov;
    logic [7:0]   r_ob, n_ob;
    logic [2:0]   r_os, n_os;

    logic [M-1:0] parent_mem [DEPTH];
    logic [7:0]   suffix_mem [DEPTH];
    logic [7:0]   stack_mem  [DEPTH];
    logic [M-1:0] r_par_q;
    logic [7:0]   r_suf_q, r_stk_q;

    logic         w_acc, w_rdy, w_kwk;
    logic [M-1:0] w_code;
    logic [M:0]   w_limit, w_nfc1;
    logic         w_stk_we, w_par_we, w_suf_we;
    logic [M-1:0] w_stk_wa, w_stk_ra;
    logic [7:0]   w_stk_wd;

    lzwz_code_unpack #(.MAX_CODE_BITS(M)) u_unpack (
        .i_group      (r_grp),
        .i_bit_pos    (r_bp),
        .i_code_width (r_cw),
        .i_group_count(r_gc),
        .o_code       (w_code),
        .o_ready      (w_rdy)
    );

    assign s_axis_tready = (r_state == lzwz_pkg::S_IDLE) && (!r_ov || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_ob;
    assign m_axis_tuser  = r_os;

    assign w_limit  = (M+1)'(1) << r_hdr[4:0];
    assign w_nfc1   = r_nfc + (M+1)'(1);
    assign w_kwk    = r_prev && ({1'b0, r_sym} == r_nfc - (M+1)'(1));
    assign w_stk_ra = r_depth - M'(1);
    assign w_par_we = (r_state == lzwz_pkg::S_WALK) && (r_cur[M-1:8] == '0) && (r_nfc < w_limit);
    assign w_suf_we = (r_state == lzwz_pkg::S_WALK) && (r_cur[M-1:8] == '0) && r_prev;

    always_comb begin
        w_stk_we = 1'b0;
        w_stk_wa = r_steps;
        w_stk_wd = r_suf_q;
        if (r_state == lzwz_pkg::S_READ) begin
            w_stk_we = 1'b1;
        end else if (r_state == lzwz_pkg::S_WALK && r_cur[M-1:8] == '0 && w_kwk) begin
            w_stk_we = 1'b1;
            w_stk_wa = '0;
            w_stk_wd = r_cur[7:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzwz_pkg::S_IDLE: begin
                if (w_acc && !r_err && s_axis_tuser != lzwz_pkg::OP_FEED) begin
                    n_state = (r_depth != '0) ? lzwz_pkg::S_POP : lzwz_pkg::S_DEC;
                end
            end
            lzwz_pkg::S_POP: n_state = lzwz_pkg::S_IDLE;
            lzwz_pkg::S_DEC: begin
                if (!w_rdy || {1'b0, w_code} >= r_nfc) begin
                    n_state = lzwz_pkg::S_IDLE;
                end else if (!(r_hdr[7] && 32'(w_code) == lzwz_pkg::CLEAR_CODE)) begin
                    n_state = lzwz_pkg::S_WALK;
                end
            end
            lzwz_pkg::S_WALK: begin
                n_state = (r_cur[M-1:8] != '0) ? lzwz_pkg::S_READ : lzwz_pkg::S_IDLE;
            end
            lzwz_pkg::S_READ: n_state = lzwz_pkg::S_WALK;
            default: n_state = lzwz_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_hdr = r_hdr; n_grp = r_grp; n_gc = r_gc; n_disc = r_disc; n_cw = r_cw;
        n_bp = r_bp; n_nfc = r_nfc; n_prev = r_prev; n_end = r_end; n_err = r_err;
        n_depth = r_depth; n_sym = r_sym; n_cur = r_cur; n_steps = r_steps;
        n_ov = r_ov && !m_axis_tready; n_ob = r_ob; n_os = r_os;
        unique case (r_state)
            lzwz_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_ov = 1'b1;
                    n_ob = 8'h00;
                    if (r_err) begin
                        n_os = lzwz_pkg::ST_ERROR;
                    end else if (s_axis_tuser == lzwz_pkg::OP_FEED) begin
                        n_os = lzwz_pkg::ST_ACCEPTED;
                        if (r_end) begin
                            n_os = lzwz_pkg::ST_REFUSED;
                        end else if (r_disc != '0) begin
                            n_disc = r_disc - 5'd1;
                        end else if (r_gc >= r_cw && w_rdy) begin
                            n_os = lzwz_pkg::ST_REFUSED;
                        end else begin
                            if (r_gc >= r_cw) begin
                                n_gc = 5'd0;
                                n_bp = 8'd0;
                            end
                            n_grp[n_gc[3:0]*8 +: 8] = s_axis_tdata;
                            n_gc = n_gc + 5'd1;
                        end
                        if (n_os == lzwz_pkg::ST_ACCEPTED && s_axis_tlast) begin
                            n_end  = 1'b1;
                            n_disc = 5'd0;
                        end
                    end else if (r_depth != '0) begin
                        n_ov    = 1'b0;
                        n_depth = r_depth - M'(1);
                    end else begin
                        n_ov = 1'b0;
                    end
                end
            end
            lzwz_pkg::S_POP: begin
                n_ov = 1'b1;
                n_ob = r_stk_q;
                n_os = lzwz_pkg::ST_BYTE;
            end
            lzwz_pkg::S_DEC: begin
                if (!w_rdy) begin
                    n_ov = 1'b1;
                    n_ob = 8'h00;
                    n_os = r_end ? lzwz_pkg::ST_FINISHED : lzwz_pkg::ST_NEED;
                end else begin
                    n_bp = r_bp + {3'b000, r_cw};
                    if ({1'b0, w_code} >= r_nfc) begin
                        n_err = 1'b1;
                        n_ov  = 1'b1;
                        n_ob  = 8'h00;
                        n_os  = lzwz_pkg::ST_ERROR;
                    end else if (r_hdr[7] && 32'(w_code) == lzwz_pkg::CLEAR_CODE) begin
                        n_disc = (r_end || r_cw <= r_gc) ? 5'd0 : r_cw - r_gc;
                        n_gc   = 5'd0;
                        n_bp   = 8'd0;
                        n_cw   = lzwz_pkg::MIN_BITS;
                        n_nfc  = (M+1)'(lzwz_pkg::FIRST_FREE);
                        n_prev = 1'b0;
                    end else begin
                        n_sym   = w_code;
                        n_cur   = w_code;
                        n_steps = '0;
                    end
                end
            end
            lzwz_pkg::S_WALK: begin
                if (r_cur[M-1:8] == '0) begin
                    n_ov    = 1'b1;
                    n_ob    = r_cur[7:0];
                    n_os    = lzwz_pkg::ST_BYTE;
                    n_depth = r_steps;
                    if (r_nfc < w_limit) begin
                        n_prev = 1'b1;
                        n_nfc  = w_nfc1;
                        if (w_nfc1 > ((M+1)'(1) << r_cw) && r_cw < r_hdr[4:0]) begin
                            n_disc = (r_end || r_cw <= r_gc) ? 5'd0 : r_cw - r_gc;
                            n_gc   = 5'd0;
                            n_bp   = 8'd0;
                            n_cw   = r_cw + 5'd1;
                        end
                    end else begin
                        n_prev = 1'b0;
                    end
                end
            end
            lzwz_pkg::S_READ: begin
                n_cur   = r_par_q;
                n_steps = r_steps + M'(1);
            end
            default: ;
        endcase
        if (i_cfg_we) begin
            n_hdr   = i_cfg_wdata;
            n_gc    = 5'd0;
            n_disc  = 5'd0;
            n_bp    = 8'd0;
            n_cw    = lzwz_pkg::MIN_BITS;
            n_nfc   = i_cfg_wdata[7] ? (M+1)'(lzwz_pkg::FIRST_FREE)
                                     : (M+1)'(lzwz_pkg::CLEAR_CODE);
            n_prev  = 1'b0;
            n_end   = 1'b0;
            n_depth = '0;
            n_err   = (i_cfg_wdata[4:0] < lzwz_pkg::MIN_BITS) ||
                      (i_cfg_wdata[4:0] > 5'(M));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzwz_pkg::S_IDLE;
            r_hdr   <= lzwz_pkg::HDR_RESET;
            r_grp   <= '0;
            r_gc    <= 5'd0;
            r_disc  <= 5'd0;
            r_bp    <= 8'd0;
            r_cw    <= lzwz_pkg::MIN_BITS;
            r_nfc   <= (M+1)'(lzwz_pkg::FIRST_FREE);
            r_prev  <= 1'b0;
            r_end   <= 1'b0;
            r_err   <= (lzwz_pkg::HDR_RESET[4:0] > 5'(M));
            r_depth <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hdr   <= n_hdr;
            r_grp   <= n_grp;
            r_gc    <= n_gc;
            r_disc  <= n_disc;
            r_bp    <= n_bp;
            r_cw    <= n_cw;
            r_nfc   <= n_nfc;
            r_prev  <= n_prev;
            r_end   <= n_end;
            r_err   <= n_err;
            r_depth <= n_depth;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym   <= n_sym;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_ob    <= n_ob;
        r_os    <= n_os;
    end

    // dictionary and stack memories
    always_ff @(posedge i_clk) begin
        if (w_par_we) begin
            parent_mem[r_nfc[M-1:0]] <= r_sym;
        end
        r_par_q <= parent_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (w_suf_we) begin
            suffix_mem[r_nfc[M-1:0] - M'(1)] <= r_cur[7:0];
        end
        r_suf_q <= suffix_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            stack_mem[w_stk_wa] <= w_stk_wd;
        end
        r_stk_q <= stack_mem[w_stk_ra];
    end

    a_busy_not_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lzwz_pkg::S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_width_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_err |-> (r_cw >= lzwz_pkg::MIN_BITS && r_cw <= 5'(M)))
        else $error("code width out of range");
    a_group_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_err |-> (r_gc <= r_cw))
        else $error("group overfilled");
    a_pop_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzwz_pkg::S_POP) |=> (r_ov && r_os == lzwz_pkg::ST_BYTE))
        else $error("pop gave no byte");
    a_walk_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzwz_pkg::S_WALK) |-> ({1'b0, r_cur} < r_nfc))
        else $error("chain walks past dictionary");
endmodule
`default_nettype wire
